// ===== sv/olt_pkg.sv =====
package olt_pkg;

    localparam int VAL_W      = 32;
    localparam int POS_W      = 4;
    localparam int SHOW_LIMIT = 16;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_SHOW   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FOUND     = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_EMPTY     = 3'd3,
        ST_FULL      = 3'd4
    } status_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    walk;
        logic    shift;
        logic    show;
        logic    push;
        logic    pop;
        logic    emit;
        status_t code;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic  full;
        logic  empty;
        logic  hit;
        logic  walk_end;
        kind_t kind;
    } stat_t;

endpackage

// ===== sv/olt_ctrl.sv =====
module olt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  olt_pkg::stat_t st,
    output olt_pkg::cmd_t  cmd,
    output logic          busy
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_WALK,
        S_SHIFT,
        S_SHOW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = olt_pkg::ST_DONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (st.kind)
                    olt_pkg::KIND_INSERT:
                    begin
                        cmd.emit   = 1'b1;
                        state_next = S_IDLE;
                        if (st.full)
                        begin
                            cmd.code = olt_pkg::ST_FULL;
                        end
                        else
                        begin
                            cmd.push = 1'b1;
                        end
                    end
                    olt_pkg::KIND_REMOVE:
                    begin
                        if (st.empty)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.code   = olt_pkg::ST_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_WALK;
                        end
                    end
                    olt_pkg::KIND_SEARCH:
                    begin
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        if (st.empty)
                        begin
                            cmd.emit   = 1'b1;
                            cmd.code   = olt_pkg::ST_EMPTY;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SHOW;
                        end
                    end
                endcase
            end
            S_WALK:
            begin
                cmd.walk = 1'b1;
                if (st.hit)
                begin
                    if (st.kind == olt_pkg::KIND_REMOVE)
                    begin
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cmd.emit   = 1'b1;
                        cmd.code   = olt_pkg::ST_FOUND;
                        state_next = S_IDLE;
                    end
                end
                else if (st.walk_end)
                begin
                    cmd.emit   = 1'b1;
                    cmd.code   = olt_pkg::ST_NOT_FOUND;
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (st.walk_end)
                begin
                    cmd.pop    = 1'b1;
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SHOW:
            begin
                cmd.show = 1'b1;
                if (st.walk_end)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

    a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (state_reg != S_IDLE))
        else $error("busy out of step with state");

    a_hit_leaves_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && st.hit) |=> (state_reg == S_SHIFT || state_reg == S_IDLE))
        else $error("walk did not stop on hit");

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy_reg)
        else $error("load did not raise busy");

endmodule

// ===== sv/olt_dp.sv =====
module olt_dp #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  olt_pkg::cmd_t                      cmd,
    input  logic [1:0]                        kind,
    input  logic signed [olt_pkg::VAL_W-1:0]  value,
    output olt_pkg::stat_t                     st,
    output logic                              strobe,
    output logic [2:0]                        status,
    output logic signed [olt_pkg::VAL_W-1:0]  item,
    output logic [olt_pkg::POS_W-1:0]         position,
    output logic                              last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [olt_pkg::VAL_W-1:0] mem [DEPTH];

    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             ptr_reg, ptr_next;
    logic                      chk_vld_reg, chk_vld_next;
    logic [CW-1:0]             chk_idx_reg, chk_idx_next;
    logic [CW-1:0]             dst_reg, dst_next;
    olt_pkg::kind_t            kind_reg, kind_next;
    logic [olt_pkg::VAL_W-1:0] val_reg, val_next;
    logic [olt_pkg::VAL_W-1:0] rd_q_reg;

    logic                      strobe_reg, strobe_next;
    logic [2:0]                status_reg, status_next;
    logic [olt_pkg::VAL_W-1:0] item_reg, item_next;
    logic [olt_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      last_reg, last_next;

    logic [CW-1:0]             lim;
    logic                      hit;
    logic                      more;
    logic                      adv;
    logic                      rd_en;
    logic                      wr_en;
    logic [CW-1:0]             wr_addr;
    logic [olt_pkg::VAL_W-1:0] wr_data;

    // show stops at the first SHOW_LIMIT entries
    always_comb
    begin
        if (kind_reg == olt_pkg::KIND_SHOW && int'(count_reg) > olt_pkg::SHOW_LIMIT)
        begin
            lim = CW'(olt_pkg::SHOW_LIMIT);
        end
        else
        begin
            lim = count_reg;
        end
    end

    assign hit   = chk_vld_reg && (rd_q_reg == val_reg);
    assign more  = (ptr_reg < lim);
    assign adv   = (cmd.walk && !hit) || cmd.shift || cmd.show;
    assign rd_en = adv && more;

    always_comb
    begin
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        chk_vld_next = chk_vld_reg;
        chk_idx_next = chk_idx_reg;
        dst_next     = dst_reg;
        kind_next    = kind_reg;
        val_next     = val_reg;
        wr_en        = 1'b0;
        wr_addr      = dst_reg;
        wr_data      = rd_q_reg;
        strobe_next  = 1'b0;
        status_next  = status_reg;
        item_next    = item_reg;
        pos_next     = pos_reg;
        last_next    = last_reg;

        if (cmd.load)
        begin
            kind_next    = olt_pkg::kind_t'(kind);
            val_next     = value;
            ptr_next     = '0;
            chk_vld_next = 1'b0;
        end

        if (cmd.walk && hit)
        begin
            chk_vld_next = 1'b0;
            dst_next     = chk_idx_reg;
        end

        if (adv)
        begin
            chk_vld_next = more;
            if (more)
            begin
                chk_idx_next = ptr_reg;
                ptr_next     = ptr_reg + CW'(1);
            end
        end

        // close the gap: entry read last cycle moves down one place
        if (cmd.shift && chk_vld_reg)
        begin
            wr_en    = 1'b1;
            wr_addr  = dst_reg;
            wr_data  = rd_q_reg;
            dst_next = dst_reg + CW'(1);
        end

        if (cmd.push)
        begin
            wr_en      = 1'b1;
            wr_addr    = count_reg;
            wr_data    = val_reg;
            count_next = count_reg + CW'(1);
        end

        if (cmd.pop)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.emit)
        begin
            strobe_next = 1'b1;
            status_next = cmd.code;
            item_next   = '0;
            pos_next    = (cmd.code == olt_pkg::ST_FOUND) ?
                          olt_pkg::POS_W'(chk_idx_reg) : '0;
            last_next   = 1'b1;
        end

        if (cmd.show && chk_vld_reg)
        begin
            strobe_next = 1'b1;
            status_next = olt_pkg::ST_DONE;
            item_next   = rd_q_reg;
            pos_next    = olt_pkg::POS_W'(chk_idx_reg);
            last_next   = ((chk_idx_reg + CW'(1)) == lim);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            ptr_reg     <= '0;
            chk_vld_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            ptr_reg     <= ptr_next;
            chk_vld_reg <= chk_vld_next;
            strobe_reg  <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        dst_reg     <= dst_next;
        kind_reg    <= kind_next;
        val_reg     <= val_next;
        status_reg  <= status_next;
        item_reg    <= item_next;
        pos_reg     <= pos_next;
        last_reg    <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr[AW-1:0]] <= wr_data;
        end
        if (rd_en)
        begin
            rd_q_reg <= mem[ptr_reg[AW-1:0]];
        end
    end

    assign st.full     = (count_reg == CW'(DEPTH));
    assign st.empty    = (count_reg == '0);
    assign st.hit      = hit;
    assign st.walk_end = !chk_vld_reg && !more;
    assign st.kind     = kind_reg;

    assign strobe   = strobe_reg;
    assign status   = status_reg;
    assign item     = item_reg;
    assign position = pos_reg;
    assign last     = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("count above depth");

    a_write_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !cmd.push) |-> (wr_addr < count_reg))
        else $error("shift write beyond list");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!st.full && !cmd.pop))
        else $error("push on full list");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("pop did not decrement count");

endmodule

// ===== sv/ordered_list_table.sv =====
// Search reads the list one entry per cycle through the read port; remove searches
// the same way, then the entries after the match move down one place, one per cycle;
// show gives one item per cycle.
// One item at a time: start is taken when busy is low; busy drops as the last result is
// registered (in the cycle after, for a show); the receiver cannot stall results.
// Reset clears the count (list empty); entry storage is not cleared.
module ordered_list_table #(
    parameter int DEPTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [1:0]                        kind,
    input  logic signed [olt_pkg::VAL_W-1:0]  value,
    output logic                              busy,
    output logic                              strobe,
    output logic [2:0]                        status,
    output logic signed [olt_pkg::VAL_W-1:0]  item,
    output logic [olt_pkg::POS_W-1:0]         position,
    output logic                              last
);

    olt_pkg::cmd_t  cmd;
    olt_pkg::stat_t st;
    logic           start_ok;

    assign start_ok = start && !busy;

    olt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_ok),
        .st    (st),
        .cmd   (cmd),
        .busy  (busy)
    );

    olt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .kind     (kind),
        .value    (value),
        .st       (st),
        .strobe   (strobe),
        .status   (status),
        .item     (item),
        .position (position),
        .last     (last)
    );

endmodule
